// ===== src/hus_pkg.sv =====
`timescale 1ns / 1ps

package hus_pkg;

    // fixed widths of the channel and register fields
    localparam int WORD_W = 32;
    localparam int CFG_W  = 16;
    localparam int HIT_W  = 16;
    localparam int IDX_W  = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CFG_W-1:0]  cfg_val_t;
    typedef logic [HIT_W-1:0]  hit_t;
    typedef logic [IDX_W-1:0]  cfg_idx_t;

    // register indexes of the configuration port
    localparam cfg_idx_t REG_POPULATION_SIZE  = 3'd0;
    localparam cfg_idx_t REG_MARKED_COUNT     = 3'd1;
    localparam cfg_idx_t REG_DRAW_COUNT       = 3'd2;
    localparam cfg_idx_t REG_EXPERIMENT_COUNT = 3'd3;

    // register values after reset
    localparam cfg_val_t RST_POPULATION_SIZE  = 16'd1;
    localparam cfg_val_t RST_MARKED_COUNT     = 16'd0;
    localparam cfg_val_t RST_DRAW_COUNT       = 16'd1;
    localparam cfg_val_t RST_EXPERIMENT_COUNT = 16'd1;

endpackage

// ===== src/hus_draw_if.sv =====
`timescale 1ns / 1ps

interface hus_draw_if
    import hus_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t uniform_word;

    modport source (output valid, output uniform_word, input ready);
    modport sink   (input valid, input uniform_word, output ready);
endinterface

// ===== src/hus_result_if.sv =====
`timescale 1ns / 1ps

interface hus_result_if
    import hus_pkg::*;
;
    logic valid;
    logic ready;
    hit_t hit_count;
    logic in_support;
    logic last_experiment;

    modport source (output valid, output hit_count, output in_support,
                    output last_experiment, input ready);
    modport sink   (input valid, input hit_count, input in_support,
                    input last_experiment, output ready);
endinterface

// ===== src/hypergeometric_urn_sampler.sv =====
`timescale 1ns / 1ps
// a word accepted into the input register is drawn once the result stage can
// take a word, and a result word that ends an experiment is registered at that draw
// throughput: one draw word per cycle unless the result side stalls, set by the single
// draw stage (one multiply and compare against the urn state, then the state update)
// reset: rst_n clears all handshake state and loads the register defaults
// (population 1, marked 0, draws 1, experiments 1) and a fresh urn

module hypergeometric_urn_sampler
    import hus_pkg::*;
#(
    parameter int COUNT_BITS  = 16,
    parameter int RANDOM_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  cfg_idx_t     cfg_index,
    input  cfg_val_t     cfg_data,
    hus_draw_if.sink     draw,
    hus_result_if.source result
);

    localparam int PROD_W = RANDOM_BITS + COUNT_BITS;
    // wide enough for every counter and register, plus sign and carry
    localparam int CMP_W  = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 2;

    typedef logic [COUNT_BITS-1:0]  cnt_t;
    typedef logic [RANDOM_BITS-1:0] rnd_t;
    typedef logic [PROD_W-1:0]      prod_t;
    typedef logic [CMP_W-1:0]       cmp_t;

    localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};
    localparam cnt_t CNT_ONE = cnt_t'(1);

    // configuration registers
    cfg_val_t population_size_reg;
    cfg_val_t marked_count_reg;
    cfg_val_t draw_count_reg;
    cfg_val_t experiment_count_reg;

    // urn state
    cnt_t remaining_marked_reg;
    cnt_t remaining_total_reg;
    cnt_t draws_done_reg;
    cnt_t hits_so_far_reg;
    cnt_t experiments_done_reg;

    // input stage
    rnd_t word_reg;
    logic word_valid_reg;

    // result stage
    logic res_valid_reg;
    hit_t res_hit_count_reg;
    logic res_in_support_reg;
    logic res_last_reg;

    // draw stage
    logic     advance;
    prod_t    product;
    prod_t    marked_scaled;
    logic     hit;
    cnt_t     remaining_marked_next;
    cnt_t     remaining_total_next;
    cnt_t     draws_done_next;
    cnt_t     hits_so_far_next;
    cfg_val_t draws_eff;
    cfg_val_t experiments_eff;
    logic     experiment_done;
    logic     last_next;
    cmp_t     low_bound;
    cmp_t     high_bound;
    cmp_t     hits_wide;
    logic     in_support_next;

    // the draw stage moves on whenever the result stage can take its word
    assign advance     = !res_valid_reg || result.ready;
    assign draw.ready  = !word_valid_reg || advance;

    assign result.valid           = res_valid_reg;
    assign result.hit_count       = res_hit_count_reg;
    assign result.in_support      = res_in_support_reg;
    assign result.last_experiment = res_last_reg;

    // hit when word * total < marked * 2^RANDOM_BITS, exact integer compare
    assign product       = prod_t'(word_reg) * prod_t'(remaining_total_reg);
    assign marked_scaled = {remaining_marked_reg, {RANDOM_BITS{1'b0}}};
    assign hit           = product < marked_scaled;

    always_comb
    begin
        remaining_marked_next = remaining_marked_reg;
        hits_so_far_next      = hits_so_far_reg;
        if (hit)
        begin
            if (remaining_marked_reg != '0)
            begin
                remaining_marked_next = remaining_marked_reg - CNT_ONE;
            end
            if (hits_so_far_reg != CNT_MAX)
            begin
                hits_so_far_next = hits_so_far_reg + CNT_ONE;
            end
        end
        // total never falls below one, and a zero population stays zero
        remaining_total_next = (remaining_total_reg > CNT_ONE) ?
                               remaining_total_reg - CNT_ONE : remaining_total_reg;
        draws_done_next      = (draws_done_reg != CNT_MAX) ?
                               draws_done_reg + CNT_ONE : draws_done_reg;
    end

    // a zero draw or experiment count behaves as one
    assign draws_eff       = (draw_count_reg == '0) ? cfg_val_t'(1) : draw_count_reg;
    assign experiments_eff = (experiment_count_reg == '0) ?
                             cfg_val_t'(1) : experiment_count_reg;

    assign experiment_done = cmp_t'(draws_done_next) >= cmp_t'(draws_eff);
    assign last_next       = (cmp_t'(experiments_done_reg) + cmp_t'(1))
                             >= cmp_t'(experiments_eff);

    // support bounds: max(0, r + M - N) to min(M, r), signed in between
    always_comb
    begin
        low_bound = cmp_t'(draws_eff) + cmp_t'(marked_count_reg)
                    - cmp_t'(population_size_reg);
        if (low_bound[CMP_W-1])
        begin
            low_bound = '0;
        end
        high_bound = (marked_count_reg < draws_eff) ?
                     cmp_t'(marked_count_reg) : cmp_t'(draws_eff);
        hits_wide       = cmp_t'(hits_so_far_next);
        in_support_next = (hits_wide >= low_bound) && (hits_wide <= high_bound);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            population_size_reg  <= RST_POPULATION_SIZE;
            marked_count_reg     <= RST_MARKED_COUNT;
            draw_count_reg       <= RST_DRAW_COUNT;
            experiment_count_reg <= RST_EXPERIMENT_COUNT;
            remaining_marked_reg <= cnt_t'(RST_MARKED_COUNT);
            remaining_total_reg  <= cnt_t'(RST_POPULATION_SIZE);
            draws_done_reg       <= '0;
            hits_so_far_reg      <= '0;
            experiments_done_reg <= '0;
            word_valid_reg       <= 1'b0;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            // input stage
            if (draw.valid && draw.ready)
            begin
                word_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                word_valid_reg <= 1'b0;
            end

            // result stage
            if (advance)
            begin
                res_valid_reg <= word_valid_reg && experiment_done;
            end

            if (cfg_we)
            begin
                // any valid register write starts a new run on a fresh urn
                unique case (cfg_index)
                    REG_POPULATION_SIZE:
                    begin
                        population_size_reg  <= cfg_data;
                        remaining_total_reg  <= cnt_t'(cfg_data);
                        remaining_marked_reg <= cnt_t'(marked_count_reg);
                        draws_done_reg       <= '0;
                        hits_so_far_reg      <= '0;
                        experiments_done_reg <= '0;
                    end
                    REG_MARKED_COUNT:
                    begin
                        marked_count_reg     <= cfg_data;
                        remaining_marked_reg <= cnt_t'(cfg_data);
                        remaining_total_reg  <= cnt_t'(population_size_reg);
                        draws_done_reg       <= '0;
                        hits_so_far_reg      <= '0;
                        experiments_done_reg <= '0;
                    end
                    REG_DRAW_COUNT:
                    begin
                        draw_count_reg       <= cfg_data;
                        remaining_marked_reg <= cnt_t'(marked_count_reg);
                        remaining_total_reg  <= cnt_t'(population_size_reg);
                        draws_done_reg       <= '0;
                        hits_so_far_reg      <= '0;
                        experiments_done_reg <= '0;
                    end
                    REG_EXPERIMENT_COUNT:
                    begin
                        experiment_count_reg <= cfg_data;
                        remaining_marked_reg <= cnt_t'(marked_count_reg);
                        remaining_total_reg  <= cnt_t'(population_size_reg);
                        draws_done_reg       <= '0;
                        hits_so_far_reg      <= '0;
                        experiments_done_reg <= '0;
                    end
                    default:
                    begin
                        // indexes beyond the register list are ignored
                    end
                endcase
            end
            else if (advance && word_valid_reg)
            begin
                if (experiment_done)
                begin
                    // reload the urn for the next experiment
                    remaining_marked_reg <= cnt_t'(marked_count_reg);
                    remaining_total_reg  <= cnt_t'(population_size_reg);
                    draws_done_reg       <= '0;
                    hits_so_far_reg      <= '0;
                    experiments_done_reg <= last_next ? '0 :
                                            experiments_done_reg + CNT_ONE;
                end
                else
                begin
                    remaining_marked_reg <= remaining_marked_next;
                    remaining_total_reg  <= remaining_total_next;
                    draws_done_reg       <= draws_done_next;
                    hits_so_far_reg      <= hits_so_far_next;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (draw.valid && draw.ready)
        begin
            word_reg <= rnd_t'(draw.uniform_word);
        end
        if (advance && word_valid_reg && experiment_done)
        begin
            res_hit_count_reg  <= hit_t'(hits_so_far_next);
            res_in_support_reg <= in_support_next;
            res_last_reg       <= last_next;
        end
    end

endmodule

// ===== tb/hypergeometric_urn_sampler_tb.sv =====
`timescale 1ns / 1ps

module hypergeometric_urn_sampler_tb
    import hus_pkg::*;
;

    // index with no register behind it: a write must change nothing
    localparam cfg_idx_t REG_UNUSED = 3'd7;

    // count wide enough for the state counters of the block
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;

    // target number of random draw words
    localparam int unsigned RANDOM_WORDS = 800;

    // one result word as the block should send it
    typedef struct packed {
        hit_t hit_count;
        logic in_support;
        logic last_experiment;
    } urn_result_t;

    // tracks the urn as the block should, one accepted draw word at a time,
    // and holds the result words still owed by the block
    class urn_draw_tracker;
        cfg_val_t population;
        cfg_val_t marked;
        cfg_val_t draws_per_exp;
        cfg_val_t exps_per_run;

        logic [CNT_W-1:0] left_marked;
        logic [CNT_W-1:0] left_total;
        logic [CNT_W-1:0] draws_done;
        logic [CNT_W-1:0] hits_so_far;
        logic [CNT_W-1:0] exps_done;

        urn_result_t owed_results[$];
        int unsigned wrong_fields;

        function new();
            population    = RST_POPULATION_SIZE;
            marked        = RST_MARKED_COUNT;
            draws_per_exp = RST_DRAW_COUNT;
            exps_per_run  = RST_EXPERIMENT_COUNT;
            exps_done     = '0;
            wrong_fields  = 0;
            refill();
        endfunction

        function void refill();
            left_marked = marked;
            left_total  = population;
            draws_done  = '0;
            hits_so_far = '0;
        endfunction

        function void write_register(input cfg_idx_t idx, input cfg_val_t val);
            case (idx)
                REG_POPULATION_SIZE:  population    = val;
                REG_MARKED_COUNT:     marked        = val;
                REG_DRAW_COUNT:       draws_per_exp = val;
                REG_EXPERIMENT_COUNT: exps_per_run  = val;
                default:              return;
            endcase
            exps_done = '0;
            refill();
        endfunction

        function void note_draw(input word_t w);
            logic [63:0] scaled_word;
            logic [63:0] scaled_marked;
            int          r_eff;
            int          e_eff;
            int          low_bound;
            int          high_bound;
            int          hits;
            logic        is_last;
            urn_result_t res;

            // exact form of: w / 2^32 < left_marked / left_total
            scaled_word   = {32'b0, w} * {48'b0, left_total};
            scaled_marked = {16'b0, left_marked, 32'b0};
            if (scaled_word < scaled_marked)
            begin
                if (left_marked != 0)
                    left_marked = left_marked - 1'b1;
                if (hits_so_far != CNT_TOP)
                    hits_so_far = hits_so_far + 1'b1;
            end
            if (left_total > 1)
                left_total = left_total - 1'b1;
            if (draws_done != CNT_TOP)
                draws_done = draws_done + 1'b1;

            // zero draw count acts as one draw per experiment
            r_eff = draws_per_exp;
            if (r_eff == 0)
                r_eff = 1;
            if (int'(draws_done) < r_eff)
                return;

            low_bound = r_eff + int'(marked) - int'(population);
            if (low_bound < 0)
                low_bound = 0;
            high_bound = (int'(marked) < r_eff) ? int'(marked) : r_eff;
            hits = hits_so_far;

            e_eff = exps_per_run;
            if (e_eff == 0)
                e_eff = 1;
            is_last = (int'(exps_done) + 1) >= e_eff;

            res.hit_count       = hits_so_far;
            res.in_support      = (hits >= low_bound) && (hits <= high_bound);
            res.last_experiment = is_last;
            owed_results = {owed_results, res};

            exps_done = is_last ? '0 : exps_done + 1'b1;
            refill();
        endfunction

        function void check_result(input hit_t hit_count, input logic in_support,
                                   input logic last_experiment);
            urn_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result word with none owed: hit_count %0d", hit_count);
                wrong_fields++;
                return;
            end
            want = owed_results.pop_front();
            if (hit_count !== want.hit_count)
            begin
                $error("hit_count: expected %0d, got %0d", want.hit_count, hit_count);
                wrong_fields++;
            end
            if (in_support !== want.in_support)
            begin
                $error("in_support: expected %0b, got %0b", want.in_support, in_support);
                wrong_fields++;
            end
            if (last_experiment !== want.last_experiment)
            begin
                $error("last_experiment: expected %0b, got %0b",
                       want.last_experiment, last_experiment);
                wrong_fields++;
            end
        endfunction

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    cfg_val_t cfg_data;

    hus_draw_if   draw_ch ();
    hus_result_if result_ch ();

    urn_draw_tracker urn = new();

    // idle control: steady stretches with no gaps, and a forced stream for
    // the long experiment
    bit src_steady;
    bit sink_steady;
    bit long_run;

    hypergeometric_urn_sampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .draw      (draw_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #1ms;
        $display("simulation failed");
        $finish;
    end

    // everything sampled here sees values from before the edge, since all
    // drivers use nonblocking assignments at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                urn.write_register(cfg_index, cfg_data);
            if (draw_ch.valid && draw_ch.ready)
                urn.note_draw(draw_ch.uniform_word);
            if (result_ch.valid && result_ch.ready)
                urn.check_result(result_ch.hit_count, result_ch.in_support,
                                 result_ch.last_experiment);
        end
    end

    // result side: random stall before each word, with steady stretches
    initial
    begin : result_sink
        int unsigned stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // one draw word, after a random gap; valid stays high if no gap follows
    task automatic send_draw(input word_t w);
        int unsigned gap;
        if (!long_run && $urandom_range(0, 15) == 0)
            src_steady = !src_steady;
        gap = (long_run || src_steady) ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            draw_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        draw_ch.valid        <= 1'b1;
        draw_ch.uniform_word <= w;
        do @(posedge clk); while (!draw_ch.ready);
    endtask

    // stop sending, wait for every owed result, then let a trailing draw
    // with no result leave the draw stage
    task automatic drain_results();
        draw_ch.valid <= 1'b0;
        @(posedge clk);
        while (urn.owed() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // cfg_we stays high across back-to-back writes; the caller lowers it
    task automatic write_reg(input cfg_idx_t idx, input cfg_val_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_urn(input cfg_val_t n_total, input cfg_val_t n_marked,
                            input cfg_val_t n_draws, input cfg_val_t n_exps);
        write_reg(REG_POPULATION_SIZE, n_total);
        write_reg(REG_MARKED_COUNT, n_marked);
        write_reg(REG_DRAW_COUNT, n_draws);
        write_reg(REG_EXPERIMENT_COUNT, n_exps);
        cfg_we <= 1'b0;
    endtask

    // random word, weighted towards the two ends and the middle of the range
    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000 ^ ($urandom() & 32'h0000_00ff);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin : stimulus
        cfg_val_t    n_total;
        cfg_val_t    n_marked;
        cfg_val_t    n_draws;
        cfg_val_t    n_exps;
        int unsigned sent;
        int unsigned n_items;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_POPULATION_SIZE;
        cfg_data             <= '0;
        draw_ch.valid        <= 1'b0;
        draw_ch.uniform_word <= '0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        long_run    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: one item, nothing marked, so never a hit
        send_draw('0);
        send_draw('1);
        drain_results();

        // small urn, two experiments of three draws, words at both ends
        load_urn(16'd4, 16'd2, 16'd3, 16'd2);
        send_draw('0);
        send_draw('1);
        send_draw(32'h8000_0000);
        send_draw(32'h7fff_ffff);
        send_draw('0);
        send_draw('1);
        drain_results();

        // zero draw count and zero experiment count: every word ends an
        // experiment and every result is the last of its run
        load_urn(16'd3, 16'd1, 16'd0, 16'd0);
        send_draw('1);
        send_draw('0);
        send_draw(32'h5555_5555);
        drain_results();

        // empty urn: hits until the marked count runs out
        load_urn(16'd0, 16'd2, 16'd3, 16'd1);
        send_draw('1);
        send_draw('1);
        send_draw('1);
        drain_results();

        // more marked than total: support bound goes through signed maths
        load_urn(16'd3, 16'd10, 16'd5, 16'd3);
        send_draw('1);
        send_draw(32'hc000_0000);
        send_draw('0);
        send_draw('1);
        send_draw(32'h1234_5678);
        drain_results();

        // a write to an unused index keeps the experiment going; a real
        // write part way through restarts the urn
        load_urn(16'd5, 16'd3, 16'd4, 16'd2);
        send_draw('0);
        send_draw('1);
        drain_results();
        write_reg(REG_UNUSED, 16'hffff);
        cfg_we <= 1'b0;
        send_draw(32'h4000_0000);
        send_draw('0);
        send_draw('1);
        drain_results();
        write_reg(REG_DRAW_COUNT, 16'd2);
        cfg_we <= 1'b0;
        send_draw('0);
        send_draw('1);
        drain_results();

        // random phases, mostly small urns so that results come often
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    n_total  = 16'hffff;
                    n_marked = ($urandom_range(0, 1) != 0) ? 16'hffff
                                                            : cfg_val_t'($urandom());
                    n_draws  = cfg_val_t'($urandom_range(0, 8));
                    n_exps   = cfg_val_t'($urandom_range(0, 3));
                end
                1:
                begin
                    n_total  = cfg_val_t'($urandom_range(0, 8));
                    n_marked = n_total + cfg_val_t'($urandom_range(1, 20));
                    n_draws  = cfg_val_t'($urandom_range(0, 12));
                    n_exps   = cfg_val_t'($urandom_range(0, 4));
                end
                2:
                begin
                    n_total  = cfg_val_t'($urandom());
                    n_marked = cfg_val_t'($urandom());
                    n_draws  = cfg_val_t'($urandom_range(0, 6));
                    n_exps   = cfg_val_t'($urandom());
                end
                default:
                begin
                    n_total  = cfg_val_t'($urandom_range(1, 24));
                    n_marked = cfg_val_t'($urandom_range(0, n_total));
                    n_draws  = cfg_val_t'($urandom_range(0, n_total + 2));
                    n_exps   = cfg_val_t'($urandom_range(0, 4));
                end
            endcase
            load_urn(n_total, n_marked, n_draws, n_exps);
            n_items = $urandom_range(10, 60);
            for (int i = 0; i < n_items; i++)
            begin
                // now and then the sender waits for the result side to empty
                if ($urandom_range(0, 40) == 0)
                    drain_results();
                send_draw(pick_word());
            end
            sent += n_items;
            drain_results();
        end

        // full-size urn with long experiments, fed as one unbroken stream
        load_urn(16'hffff, cfg_val_t'($urandom()), 16'd125, 16'hffff);
        long_run = 1'b1;
        for (int i = 0; i < 250; i++)
            send_draw($urandom());
        long_run = 1'b0;
        drain_results();

        load_urn(16'hffff, 16'hffff, 16'd3, 16'd2);
        for (int i = 0; i < 12; i++)
            send_draw(pick_word());
        drain_results();

        repeat (10) @(posedge clk);
        if (urn.wrong_fields == 0 && urn.owed() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
